// ----- src/lrf_pkg.sv -----
// Shared constants, codes and types of the log record FIFO.
`default_nettype none
package lrf_pkg;

    localparam int LRF_DEPTH       = 16;
    localparam int LRF_ARG_COUNT   = 5;
    localparam int LRF_WORD_BITS   = 32;
    localparam int LRF_QUEUE_DEPTH = 2;
    localparam int LRF_QUEUE_PTR_W = $clog2(LRF_QUEUE_DEPTH);
    localparam int LRF_QUEUE_CNT_W = $clog2(LRF_QUEUE_DEPTH + 1);

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic [1:0] WS_NONE           = 2'd0;
    localparam logic [1:0] WS_STORED         = 2'd1;
    localparam logic [1:0] WS_DROPPED        = 2'd2;
    localparam logic [1:0] WS_MARKER_DROPPED = 2'd3;

    typedef logic [LRF_WORD_BITS-1:0] word_t;
    typedef logic [LRF_ARG_COUNT-1:0][LRF_WORD_BITS-1:0] arg_vec_t;

    localparam word_t WORD_ONE = word_t'(1);

    typedef struct packed {
        logic     is_read;
        word_t    format_id;
        arg_vec_t args;
    } cmd_t;

    typedef struct packed {
        logic     marker;
        word_t    format_id;
        arg_vec_t args;
    } rec_t;

endpackage
`default_nettype wire

// ----- src/lrf_front.sv -----
// Input stage that accepts beats and classifies them into read and write commands.
`default_nettype none
module lrf_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic                opcode,
    input  wire lrf_pkg::word_t      format_id,
    input  wire lrf_pkg::word_t      arg_one,
    input  wire lrf_pkg::word_t      arg_two,
    input  wire lrf_pkg::word_t      arg_three,
    input  wire lrf_pkg::word_t      arg_four,
    input  wire lrf_pkg::word_t      arg_five,
    input  wire logic                queue_full,
    output logic                     push_valid,
    output lrf_pkg::cmd_t            push_cmd
);
    import lrf_pkg::*;

    logic stage_valid_reg;
    logic stage_valid_next;
    cmd_t stage_cmd_reg;
    cmd_t stage_cmd_next;
    logic accept;

    assign in_stall   = stage_valid_reg && queue_full;
    assign accept     = in_valid && !in_stall;
    assign push_valid = stage_valid_reg && !queue_full;
    assign push_cmd   = stage_cmd_reg;

    always_comb
    begin
        stage_valid_next = accept || (stage_valid_reg && queue_full);
        stage_cmd_next   = stage_cmd_reg;
        if (accept)
        begin
            stage_cmd_next.is_read = (opcode == OP_READ);
            if (opcode == OP_READ)
            begin
                stage_cmd_next.format_id = '0;
                stage_cmd_next.args      = '0;
            end
            else
            begin
                stage_cmd_next.format_id = format_id;
                stage_cmd_next.args      = {arg_five, arg_four, arg_three, arg_two, arg_one};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_cmd_reg <= stage_cmd_next;
    end

endmodule
`default_nettype wire

// ----- src/lrf_cmd_queue.sv -----
// Short command queue between the input stage and the record sequencer.
`default_nettype none
module lrf_cmd_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push_valid,
    input  wire lrf_pkg::cmd_t push_cmd,
    output logic               full,
    input  wire logic          pop,
    output logic               not_empty,
    output lrf_pkg::cmd_t      pop_cmd
);
    import lrf_pkg::*;

    localparam logic [LRF_QUEUE_CNT_W-1:0] CNT_FULL = LRF_QUEUE_CNT_W'(LRF_QUEUE_DEPTH);
    localparam logic [LRF_QUEUE_CNT_W-1:0] CNT_ONE  = LRF_QUEUE_CNT_W'(1);
    localparam logic [LRF_QUEUE_PTR_W-1:0] PTR_LAST = LRF_QUEUE_PTR_W'(LRF_QUEUE_DEPTH - 1);
    localparam logic [LRF_QUEUE_PTR_W-1:0] PTR_ONE  = LRF_QUEUE_PTR_W'(1);

    cmd_t                       entry_reg [LRF_QUEUE_DEPTH];
    logic [LRF_QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [LRF_QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [LRF_QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [LRF_QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [LRF_QUEUE_CNT_W-1:0] count_reg;
    logic [LRF_QUEUE_CNT_W-1:0] count_next;
    logic                       do_push;
    logic                       do_pop;

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign pop_cmd   = entry_reg[rd_ptr_reg];
    assign do_push   = push_valid && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_ONE;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_ONE;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_ONE;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

// ----- src/lrf_back.sv -----
// Record sequencer with the ring memory, loss counter, level tracking and result register.
`default_nettype none
module lrf_back #(
    parameter int DEPTH = lrf_pkg::LRF_DEPTH
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cmd_valid,
    input  wire lrf_pkg::cmd_t             cmd,
    output logic                           cmd_pop,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic [1:0]                     write_status,
    output logic                           marker_also_written,
    output logic                           read_valid,
    output logic                           read_is_marker,
    output lrf_pkg::word_t                 out_format_id,
    output lrf_pkg::word_t                 out_arg_one,
    output lrf_pkg::word_t                 out_arg_two,
    output lrf_pkg::word_t                 out_arg_three,
    output lrf_pkg::word_t                 out_arg_four,
    output lrf_pkg::word_t                 out_arg_five,
    output logic [$clog2(DEPTH + 1)-1:0]   free_slots,
    output logic [$clog2(DEPTH + 1)-1:0]   min_free_seen
);
    import lrf_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int PTR_W = $clog2(DEPTH);

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_WRITE2 = 2'd1;
    localparam logic [1:0] ST_READ   = 2'd2;

    rec_t             mem [DEPTH];
    rec_t             rdata_reg;
    logic             mem_we;
    rec_t             mem_wdata;
    logic             rd_en;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    cmd_t             hold_reg;
    cmd_t             hold_next;
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] free_reg;
    logic [CNT_W-1:0] free_next;
    logic [CNT_W-1:0] lowest_reg;
    logic [CNT_W-1:0] lowest_next;
    logic [CNT_W-1:0] free_less;
    logic [CNT_W-1:0] lowest_less;
    word_t            lost_reg;
    word_t            lost_next;
    word_t            lost_sat;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic [1:0]       status_reg;
    logic [1:0]       status_next;
    logic             marker_wr_reg;
    logic             marker_wr_next;
    logic             rvalid_reg;
    logic             rvalid_next;
    logic             rmarker_reg;
    logic             rmarker_next;
    word_t            rformat_reg;
    word_t            rformat_next;
    arg_vec_t         rargs_reg;
    arg_vec_t         rargs_next;
    logic [CNT_W-1:0] rfree_reg;
    logic [CNT_W-1:0] rfree_next;
    logic [CNT_W-1:0] rlowest_reg;
    logic [CNT_W-1:0] rlowest_next;

    logic             can_emit;
    logic             start;
    logic [PTR_W-1:0] wr_ptr_inc;
    logic [PTR_W-1:0] rd_ptr_inc;

    assign can_emit    = !out_valid_reg || !out_stall;
    assign start       = (state_reg == ST_IDLE) && cmd_valid && can_emit;
    assign cmd_pop     = start;
    assign wr_ptr_inc  = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_ONE;
    assign rd_ptr_inc  = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_ONE;
    assign free_less   = free_reg - CNT_ONE;
    assign lowest_less = (free_less < lowest_reg) ? free_less : lowest_reg;
    assign lost_sat    = (lost_reg == '1) ? lost_reg : lost_reg + WORD_ONE;

    always_comb
    begin
        state_next     = state_reg;
        hold_next      = hold_reg;
        wr_ptr_next    = wr_ptr_reg;
        rd_ptr_next    = rd_ptr_reg;
        free_next      = free_reg;
        lowest_next    = lowest_reg;
        lost_next      = lost_reg;
        mem_we         = 1'b0;
        mem_wdata      = '0;
        rd_en          = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        marker_wr_next = marker_wr_reg;
        rvalid_next    = rvalid_reg;
        rmarker_next   = rmarker_reg;
        rformat_next   = rformat_reg;
        rargs_next     = rargs_reg;
        rfree_next     = rfree_reg;
        rlowest_next   = rlowest_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (cmd.is_read)
                    begin
                        if (free_reg != CNT_FULL)
                        begin
                            rd_en       = 1'b1;
                            rd_ptr_next = rd_ptr_inc;
                            free_next   = free_reg + CNT_ONE;
                            state_next  = ST_READ;
                        end
                        else
                        begin
                            out_valid_next = 1'b1;
                            status_next    = WS_NONE;
                            marker_wr_next = 1'b0;
                            rvalid_next    = 1'b0;
                            rmarker_next   = 1'b0;
                            rformat_next   = '0;
                            rargs_next     = '0;
                            rfree_next     = free_reg;
                            rlowest_next   = lowest_reg;
                        end
                    end
                    else if (free_reg != '0 && lost_reg != '0)
                    begin
                        mem_we              = 1'b1;
                        mem_wdata.marker    = 1'b1;
                        mem_wdata.format_id = '0;
                        mem_wdata.args      = '0;
                        mem_wdata.args[0]   = lost_reg;
                        wr_ptr_next         = wr_ptr_inc;
                        free_next           = free_less;
                        lowest_next         = lowest_less;
                        lost_next           = '0;
                        hold_next           = cmd;
                        state_next          = ST_WRITE2;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        marker_wr_next = 1'b0;
                        rvalid_next    = 1'b0;
                        rmarker_next   = 1'b0;
                        rformat_next   = '0;
                        rargs_next     = '0;
                        if (free_reg == '0)
                        begin
                            lost_next    = lost_sat;
                            status_next  = WS_DROPPED;
                            rfree_next   = free_reg;
                            rlowest_next = lowest_reg;
                        end
                        else
                        begin
                            mem_we              = 1'b1;
                            mem_wdata.marker    = 1'b0;
                            mem_wdata.format_id = cmd.format_id;
                            mem_wdata.args      = cmd.args;
                            wr_ptr_next         = wr_ptr_inc;
                            free_next           = free_less;
                            lowest_next         = lowest_less;
                            status_next         = WS_STORED;
                            rfree_next          = free_less;
                            rlowest_next        = lowest_less;
                        end
                    end
                end
            end
            ST_WRITE2:
            begin
                out_valid_next = 1'b1;
                marker_wr_next = 1'b1;
                rvalid_next    = 1'b0;
                rmarker_next   = 1'b0;
                rformat_next   = '0;
                rargs_next     = '0;
                state_next     = ST_IDLE;
                if (free_reg == '0)
                begin
                    lost_next    = lost_sat;
                    status_next  = WS_MARKER_DROPPED;
                    rfree_next   = free_reg;
                    rlowest_next = lowest_reg;
                end
                else
                begin
                    mem_we              = 1'b1;
                    mem_wdata.marker    = 1'b0;
                    mem_wdata.format_id = hold_reg.format_id;
                    mem_wdata.args      = hold_reg.args;
                    wr_ptr_next         = wr_ptr_inc;
                    free_next           = free_less;
                    lowest_next         = lowest_less;
                    status_next         = WS_STORED;
                    rfree_next          = free_less;
                    rlowest_next        = lowest_less;
                end
            end
            ST_READ:
            begin
                out_valid_next = 1'b1;
                status_next    = WS_NONE;
                marker_wr_next = 1'b0;
                rvalid_next    = 1'b1;
                rmarker_next   = rdata_reg.marker;
                rformat_next   = rdata_reg.format_id;
                rargs_next     = rdata_reg.args;
                rfree_next     = free_reg;
                rlowest_next   = lowest_reg;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            free_reg      <= CNT_FULL;
            lowest_reg    <= CNT_FULL;
            lost_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            free_reg      <= free_next;
            lowest_reg    <= lowest_next;
            lost_reg      <= lost_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg      <= hold_next;
        status_reg    <= status_next;
        marker_wr_reg <= marker_wr_next;
        rvalid_reg    <= rvalid_next;
        rmarker_reg   <= rmarker_next;
        rformat_reg   <= rformat_next;
        rargs_reg     <= rargs_next;
        rfree_reg     <= rfree_next;
        rlowest_reg   <= rlowest_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_ptr_reg] <= mem_wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_ptr_reg];
        end
    end

    assign out_valid           = out_valid_reg;
    assign write_status        = status_reg;
    assign marker_also_written = marker_wr_reg;
    assign read_valid          = rvalid_reg;
    assign read_is_marker      = rmarker_reg;
    assign out_format_id       = rformat_reg;
    assign out_arg_one         = rargs_reg[0];
    assign out_arg_two         = rargs_reg[1];
    assign out_arg_three       = rargs_reg[2];
    assign out_arg_four        = rargs_reg[3];
    assign out_arg_five        = rargs_reg[4];
    assign free_slots          = rfree_reg;
    assign min_free_seen       = rlowest_reg;

endmodule
`default_nettype wire

// ----- src/log_record_fifo_with_loss_marker.sv -----
// Top level of the log record FIFO with loss marker.
// A ring FIFO of DEPTH log records, each a format id and five argument words. A write beat
// that finds no free slot is dropped and counted; once a slot frees up, the next write first
// stores a loss marker holding that count (in the first argument word) and then the record
// itself if a slot is still left, else that record is dropped and counted. A read beat pops
// the oldest record. Every beat gives exactly one result beat that also reports the free-slot
// count and the lowest free count since reset. Beats enter through an input register and a
// two-entry command queue, so input is taken while a result waits. The record sequencer
// behind the queue owns the single-port record memory: a plain write or a read of an empty
// FIFO is done in the idle state, a read also passes the read state (registered memory read),
// and a write led by a loss marker also passes the second write state (two memory writes).
`default_nettype none
module log_record_fifo_with_loss_marker #(
    parameter int DEPTH = lrf_pkg::LRF_DEPTH
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic                      opcode,
    input  wire lrf_pkg::word_t            format_id,
    input  wire lrf_pkg::word_t            arg_one,
    input  wire lrf_pkg::word_t            arg_two,
    input  wire lrf_pkg::word_t            arg_three,
    input  wire lrf_pkg::word_t            arg_four,
    input  wire lrf_pkg::word_t            arg_five,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic [1:0]                     write_status,
    output logic                           marker_also_written,
    output logic                           read_valid,
    output logic                           read_is_marker,
    output lrf_pkg::word_t                 out_format_id,
    output lrf_pkg::word_t                 out_arg_one,
    output lrf_pkg::word_t                 out_arg_two,
    output lrf_pkg::word_t                 out_arg_three,
    output lrf_pkg::word_t                 out_arg_four,
    output lrf_pkg::word_t                 out_arg_five,
    output logic [$clog2(DEPTH + 1)-1:0]   free_slots,
    output logic [$clog2(DEPTH + 1)-1:0]   min_free_seen
);
    import lrf_pkg::*;

    logic queue_full;
    logic push_valid;
    cmd_t push_cmd;
    logic cmd_pop;
    logic cmd_valid;
    cmd_t cmd;

    lrf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .format_id  (format_id),
        .arg_one    (arg_one),
        .arg_two    (arg_two),
        .arg_three  (arg_three),
        .arg_four   (arg_four),
        .arg_five   (arg_five),
        .queue_full (queue_full),
        .push_valid (push_valid),
        .push_cmd   (push_cmd)
    );

    lrf_cmd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .full       (queue_full),
        .pop        (cmd_pop),
        .not_empty  (cmd_valid),
        .pop_cmd    (cmd)
    );

    lrf_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd_valid           (cmd_valid),
        .cmd                 (cmd),
        .cmd_pop             (cmd_pop),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .write_status        (write_status),
        .marker_also_written (marker_also_written),
        .read_valid          (read_valid),
        .read_is_marker      (read_is_marker),
        .out_format_id       (out_format_id),
        .out_arg_one         (out_arg_one),
        .out_arg_two         (out_arg_two),
        .out_arg_three       (out_arg_three),
        .out_arg_four        (out_arg_four),
        .out_arg_five        (out_arg_five),
        .free_slots          (free_slots),
        .min_free_seen       (min_free_seen)
    );

endmodule
`default_nettype wire
